/* sv/utc_pkg.sv */
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types, constants and code point mapping for the UTF-8 to CP1252
// transcoder.
// ----------------------------------------------------------------------------
package utc_pkg;

	localparam int unsigned MaxRes = 4;

	localparam logic [7:0] Replacement = 8'h3F;
	localparam logic [7:0] Lead2Lo     = 8'hC2;
	localparam logic [7:0] Lead2Hi     = 8'hDF;
	localparam logic [7:0] Lead3Lo     = 8'hE0;
	localparam logic [7:0] Lead3Hi     = 8'hEF;
	localparam logic [7:0] Lead4Lo     = 8'hF0;
	localparam logic [7:0] Lead4Hi     = 8'hF4;

	// continuation bytes still needed after a lead byte
	localparam logic [1:0] Need1 = 2'd1;
	localparam logic [1:0] Need2 = 2'd2;
	localparam logic [1:0] Need3 = 2'd3;

	// results of one input beat, first result in the lowest slot
	typedef struct packed {
		logic [MaxRes-1:0][7:0] data;
		logic [2:0]             n;
		logic                   str_end;
	} utc_res_t;

	// held lead byte and continuation bytes
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
	} utc_state_t;

	function automatic logic is_lead(input logic [7:0] b);
		return (b >= Lead2Lo) && (b <= Lead4Hi);
	endfunction

	function automatic logic [1:0] cont_need(input logic [7:0] lead);
		logic [1:0] need;
		if (lead >= Lead2Lo && lead <= Lead2Hi) begin
			need = Need1;
		end else if (lead >= Lead3Lo && lead <= Lead3Hi) begin
			need = Need2;
		end else begin
			need = Need3;
		end
		return need;
	endfunction

	// code point to cp1252 byte
	function automatic logic [7:0] map_point(input logic [15:0] cp);
		logic [7:0] r;
		if (cp <= 16'h007F || (cp >= 16'h00A0 && cp <= 16'h00FF)) begin
			r = cp[7:0];
		end else begin
			unique case (cp)
				16'h20AC: r = 8'h80;
				16'h201A: r = 8'h82;
				16'h0192: r = 8'h83;
				16'h201E: r = 8'h84;
				16'h2026: r = 8'h85;
				16'h2020: r = 8'h86;
				16'h2021: r = 8'h87;
				16'h02C6: r = 8'h88;
				16'h2030: r = 8'h89;
				16'h0160: r = 8'h8A;
				16'h2039: r = 8'h8B;
				16'h0152: r = 8'h8C;
				16'h017D: r = 8'h8E;
				16'h2018: r = 8'h91;
				16'h2019: r = 8'h92;
				16'h201C: r = 8'h93;
				16'h201D: r = 8'h94;
				16'h2022: r = 8'h95;
				16'h2013: r = 8'h96;
				16'h2014: r = 8'h97;
				16'h02DC: r = 8'h98;
				16'h2122: r = 8'h99;
				16'h0161: r = 8'h9A;
				16'h203A: r = 8'h9B;
				16'h0153: r = 8'h9C;
				16'h017E: r = 8'h9E;
				16'h0178: r = 8'h9F;
				default:  r = Replacement;
			endcase
		end
		return r;
	endfunction

endpackage

/* sv/utc_step.sv */
// ----------------------------------------------------------------------------
// utc_step
// Input stage: registers the accepted input beat and the held sequence, and
// moves both on when the beat leaves for the decoder and result register.
// ----------------------------------------------------------------------------
module utc_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,  // [7:0] in_byte
	input  logic                s_axis_tlast,
	input  logic                adv,
	input  utc_pkg::utc_state_t nxt,
	output logic                vld_s1,
	output logic [7:0]          byte_s1,
	output logic                last_s1,
	output utc_pkg::utc_state_t st_q
);

	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= nxt;
		end
	end

endmodule

/* sv/utc_decode.sv */
// ----------------------------------------------------------------------------
// utc_decode
// Combinational decode of one input byte against the held sequence: gives the
// result bytes of the beat and the next held state.
// ----------------------------------------------------------------------------
module utc_decode (
	input  logic [7:0]          in_byte,
	input  logic                string_last,
	input  utc_pkg::utc_state_t st,
	output utc_pkg::utc_res_t   res,
	output utc_pkg::utc_state_t nxt
);
	import utc_pkg::*;

	logic [1:0]             need;
	logic [1:0]             have;
	logic                   cont;
	logic                   lead_hold;
	logic [15:0]            cp2;
	logic [15:0]            cp3;
	logic [7:0]             done_byte;
	logic [MaxRes-1:0][7:0] raw;
	logic [2:0]             cnt_w;

	assign need      = cont_need(st.bytes[0]);
	assign have      = st.cnt - 2'd1;
	assign cont      = (in_byte[7:6] == 2'b10);
	assign lead_hold = is_lead(in_byte) && !string_last;
	assign cp2       = {5'b0, st.bytes[0][4:0], in_byte[5:0]};
	assign cp3       = {st.bytes[0][3:0], st.bytes[1][5:0], in_byte[5:0]};
	assign cnt_w     = {1'b0, st.cnt};

	always_comb begin
		unique case (need)
			Need1:   done_byte = map_point(cp2);
			Need2:   done_byte = map_point(cp3);
			default: done_byte = Replacement;
		endcase
	end

	// held bytes in order, then the new byte
	assign raw[0] = (st.cnt > 2'd0) ? st.bytes[0] : in_byte;
	assign raw[1] = (st.cnt > 2'd1) ? st.bytes[1] : in_byte;
	assign raw[2] = (st.cnt > 2'd2) ? st.bytes[2] : in_byte;
	assign raw[3] = in_byte;

	always_comb begin
		res.data    = '0;
		res.n       = 3'd0;
		res.str_end = string_last;
		nxt         = st;
		if (st.cnt == 2'd0) begin
			if (lead_hold) begin
				nxt.bytes[0] = in_byte;
				nxt.cnt      = 2'd1;
			end else begin
				res.data[0] = in_byte;
				res.n       = 3'd1;
			end
		end else if (cont) begin
			if (have + 2'd1 == need) begin
				res.data[0] = done_byte;
				res.n       = 3'd1;
				nxt.cnt     = 2'd0;
			end else if (!string_last && st.cnt != 2'd3) begin
				nxt.bytes[st.cnt] = in_byte;
				nxt.cnt           = st.cnt + 2'd1;
			end else begin
				// string ended inside a sequence
				res.data = raw;
				res.n    = cnt_w + 3'd1;
				nxt.cnt  = 2'd0;
			end
		end else begin
			// wrong continuation: flush, then treat the byte as fresh
			res.data = raw;
			if (lead_hold) begin
				res.n        = cnt_w;
				nxt.bytes[0] = in_byte;
				nxt.cnt      = 2'd1;
			end else begin
				res.n   = cnt_w + 3'd1;
				nxt.cnt = 2'd0;
			end
		end
	end

endmodule

/* sv/utc_out_buf.sv */
// ----------------------------------------------------------------------------
// utc_out_buf
// Result register: holds the results of one beat and shifts them out one
// beat at a time on the master side.
// ----------------------------------------------------------------------------
module utc_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  utc_pkg::utc_res_t res,
	output logic              free,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [7:0] out_byte
	output logic              m_axis_tlast,
	output logic              m_axis_tuser   // [0] string_end
);
	import utc_pkg::*;

	logic [MaxRes-1:0][7:0] data_q;
	logic [2:0]             cnt_q;
	logic                   str_q;
	logic                   take;

	assign take          = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign m_axis_tdata  = data_q[0];
	assign m_axis_tlast  = (cnt_q == 3'd1);
	assign m_axis_tuser  = (cnt_q == 3'd1) && str_q;
	assign free          = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= res.n;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res.data;
			str_q  <= res.str_end;
		end else if (take) begin
			data_q <= {8'h00, data_q[MaxRes-1:1]};
		end
	end

endmodule

/* sv/utf8_to_cp1252_transcoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_to_cp1252_transcoder_core
// Path: input beat register, combinational decode, result register to output.
// Throughput: one input beat per cycle while each gives at most one result and
// the output is not stalled; a beat with several results holds the input until
// all have left. Beats only extending a held sequence give no output and never
// stall. Reset: arst_n clears the input stage, held sequence and result
// register; the block is ready for input as soon as reset is released.
// ----------------------------------------------------------------------------
module utf8_to_cp1252_transcoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic       m_axis_tuser   // [0] string_end
);
	import utc_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	utc_state_t st_q;
	utc_state_t nxt;
	utc_res_t   res;
	logic       free;
	logic       adv;

	// beats with no result never wait on the result register
	assign adv = vld_s1 && ((res.n == 3'd0) || free);

	utc_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.adv           (adv),
		.nxt           (nxt),
		.vld_s1        (vld_s1),
		.byte_s1       (byte_s1),
		.last_s1       (last_s1),
		.st_q          (st_q)
	);

	utc_decode u_decode (
		.in_byte     (byte_s1),
		.string_last (last_s1),
		.st          (st_q),
		.res         (res),
		.nxt         (nxt)
	);

	utc_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv && (res.n != 3'd0)),
		.res           (res),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

/* sv/utc_checker.sv */
// ----------------------------------------------------------------------------
// utc_checker
// Port-level checks on the transcoder's output stream.
// ----------------------------------------------------------------------------
module utc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       m_axis_tuser
);

	// a stalled beat stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat withdrawn while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	// string end only on the last result of a run
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("string end without run end");

	// only raw flushes give several results, and those held bytes are all high
	a_flush_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[7])
		else $error("non-final result of a run below 0x80");

endmodule

bind utf8_to_cp1252_transcoder_core utc_checker u_utc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
